// File: hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Word formats and codes shared by the double-ended queue and its users.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Action codes carried by a command word
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_DUMP       = 3'd4;

  // Status codes carried by a result word
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] data;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic               last;
    logic [5:0]         occupancy;
  } res_word_t;

endpackage

// File: hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit words kept as a ring in one
// synchronous memory with a single write and a single read port.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH words. Pushes, and every command that needs no
// memory read (pop or dump on an empty queue, push on a full one, unknown
// actions), are done without leaving S_IDLE, so such commands can stream one per cycle
// while the result side keeps up. A pop first issues the memory read, then
// moves the registered read data into the result register from S_READ. A
// dump issues one memory read per entry. Commands are handled one at a time;
// the result register lets the next command in while the previous result is
// being taken. The memory needs no clearing after reset: only occupied
// entries are ever read.
module double_ended_queue #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  dq_pkg::cmd_word_t  cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output dq_pkg::res_word_t  res
);
  import dq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DUMP = 3'b100
  } state_t;

  state_t          state, state_next;
  logic [IW-1:0]   front, front_next;
  logic [CW-1:0]   count, count_next;
  logic [IW-1:0]   idx, idx_next;

  logic [31:0]     mem [DEPTH];
  logic [31:0]     rd_data;
  logic            wr_en, rd_en;
  logic [IW-1:0]   wr_addr, rd_addr;

  logic            accept, out_free, load, is_full, is_empty, dump_last;
  res_word_t       load_word;

  // Ring position: base plus offset, wrapped once at DEPTH
  function automatic logic [IW-1:0] ring(input logic [IW-1:0] base,
                                         input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (IW+1)'(DEPTH)) s = s - (IW+1)'(DEPTH);
    return s[IW-1:0];
  endfunction

  assign out_free  = !res_valid || !res_stall;
  assign cmd_stall = !((state == S_IDLE) && out_free);
  assign accept    = cmd_valid && !cmd_stall;
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);
  assign dump_last = ((CW'(idx) + CW'(1)) == count);

  // Command decode and sequencing
  always_comb begin
    state_next = state;
    front_next = front;
    count_next = count;
    idx_next   = idx;
    wr_en      = 1'b0;
    wr_addr    = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    load       = 1'b0;
    load_word  = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.action)
            ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
              load           = 1'b1;
              load_word.last = 1'b1;
              if (is_full) begin
                load_word.status    = ST_FULL;
                load_word.occupancy = 6'(count);
              end else begin
                wr_en = 1'b1;
                if (cmd.action == ACT_PUSH_FRONT) begin
                  wr_addr    = ring(front, IW'(DEPTH - 1));
                  front_next = wr_addr;
                end else begin
                  wr_addr = ring(front, IW'(count));
                end
                count_next          = count + CW'(1);
                load_word.status    = ST_DONE;
                load_word.occupancy = 6'(count_next);
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
              if (is_empty) begin
                load                = 1'b1;
                load_word.status    = ST_EMPTY;
                load_word.last      = 1'b1;
                load_word.occupancy = 6'(count);
              end else begin
                rd_en = 1'b1;
                if (cmd.action == ACT_POP_FRONT) begin
                  rd_addr    = front;
                  front_next = ring(front, IW'(1));
                end else begin
                  rd_addr = ring(front, IW'(count - CW'(1)));
                end
                count_next = count - CW'(1);
                state_next = S_READ;
              end
            end
            ACT_DUMP: begin
              if (is_empty) begin
                load                = 1'b1;
                load_word.status    = ST_EMPTY;
                load_word.last      = 1'b1;
                load_word.occupancy = 6'(count);
              end else begin
                rd_en      = 1'b1;
                rd_addr    = front;
                idx_next   = '0;
                state_next = S_DUMP;
              end
            end
            default: begin
              // unknown action: no-op, report current fill
              load                = 1'b1;
              load_word.status    = ST_DONE;
              load_word.last      = 1'b1;
              load_word.occupancy = 6'(count);
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load                = 1'b1;
          load_word.status    = ST_DONE;
          load_word.value     = rd_data;
          load_word.last      = 1'b1;
          load_word.occupancy = 6'(count);
          state_next          = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          load                = 1'b1;
          load_word.status    = ST_DONE;
          load_word.value     = rd_data;
          load_word.last      = dump_last;
          load_word.occupancy = 6'(count);
          if (dump_last) begin
            state_next = S_IDLE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = ring(front, idx + IW'(1));
            idx_next = idx + IW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= cmd.data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      idx   <= idx_next;
      if (load) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) res <= load_word;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    accept && !is_empty &&
    (cmd.action == ACT_POP_FRONT || cmd.action == ACT_POP_BACK)
    |=> (count == $past(count) - CW'(1)) && (state == S_READ))
    else $error("pop did not remove one entry");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    accept && is_full &&
    (cmd.action == ACT_PUSH_BACK || cmd.action == ACT_PUSH_FRONT)
    |=> $stable(count) && $stable(front))
    else $error("push on full queue changed state");

  a_dump_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |=> $stable(count) && $stable(front))
    else $error("queue changed during dump");

  a_dump_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) && load && dump_last |=> (state == S_IDLE))
    else $error("dump did not end after its last entry");

endmodule
